FILE: rtl/strip_fan_to_triangle_list_unit_assert.svh
// Assertion macros used by the strip and fan converter checker.
`ifndef STRIP_FAN_TO_TRIANGLE_LIST_UNIT_ASSERT_SVH
`define STRIP_FAN_TO_TRIANGLE_LIST_UNIT_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define SFTL_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sftl check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define SFTL_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sftl check failed");

`endif

FILE: rtl/sftl_pkg.sv
// Types and constants of the strip and fan to triangle list converter.
`timescale 1ns / 1ps
package sftl_pkg;

    localparam int WORD_W      = 16;
    localparam int INDEX_W     = 15;
    localparam int VERT_W      = INDEX_W + 2 * WORD_W;
    localparam int TOTAL_W     = 24;
    localparam int TOTAL_LSB   = 3 * VERT_W;
    localparam int OUT_DATA_W  = ((TOTAL_LSB + TOTAL_W + 7) / 8) * 8;
    localparam int PAD_W       = OUT_DATA_W - TOTAL_LSB - TOTAL_W;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    // Result kinds carried on tuser
    localparam logic KIND_TRIANGLE = 1'b0;
    localparam logic KIND_MESH_END = 1'b1;

    // One vertex; index sits in the low bits
    typedef struct packed {
        logic [WORD_W-1:0]  t;
        logic [WORD_W-1:0]  s;
        logic [INDEX_W-1:0] index;
    } vert_t;

    // Position within the command stream
    typedef enum logic [2:0] {
        PH_HEADER,
        PH_INDEX,
        PH_NORMAL,
        PH_S,
        PH_T
    } phase_t;

endpackage

FILE: rtl/strip_fan_to_triangle_list_unit.sv
// Top level of the triangle strip and fan to triangle list converter.
`timescale 1ns / 1ps
// Takes one 16-bit command word per transaction on s_axis and sustains one
// word per clock cycle unless m_axis stalls. A result appears on m_axis in
// the cycle after the word that causes it (the fourth word of the third and
// later vertices of a run, or a zero header). The only storage on the result
// path is a single output register; while it holds a result that m_axis has
// not taken, s_axis_tready is low, so the downstream side alone sets the rate.
module strip_fan_to_triangle_list_unit (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // word
    input  logic signed [sftl_pkg::WORD_W-1:0]   s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // corner_a_index, corner_a_s, corner_a_t, corner_b_index, corner_b_s,
    // corner_b_t, corner_c_index, corner_c_s, corner_c_t, mesh_corner_total,
    // zero pad
    output logic [sftl_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    // kind
    output logic [0:0]                           m_axis_tuser
);
    import sftl_pkg::*;

    phase_t              phase_reg, phase_next;
    logic [WORD_W-1:0]   vleft_reg, vleft_next;
    logic                fan_reg, fan_next;
    logic [WORD_W-1:0]   pos_reg, pos_next;
    vert_t               cur_reg, cur_next;
    vert_t               first_reg, first_next;
    vert_t               prev_reg, prev_next;
    logic [TOTAL_W-1:0]  total_reg, total_next;

    logic                   out_valid_reg, out_valid_next;
    logic                   out_kind_reg, out_kind_next;
    logic [OUT_DATA_W-1:0]  out_data_reg, out_data_next;

    logic                accept;
    logic [WORD_W-1:0]   w;
    vert_t               cur_full;
    logic                emit;
    logic                emit_kind;
    vert_t               tri_a, tri_b, tri_c;
    logic                last_vertex;

    assign w             = s_axis_tdata;
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign cur_full      = '{t: w, s: cur_reg.s, index: cur_reg.index};
    assign last_vertex   = (vleft_reg <= WORD_W'(1));

    // Next phase of the command stream
    always_comb
    begin
        phase_next = phase_reg;
        if (accept)
        begin
            case (phase_reg)
                PH_HEADER: phase_next = (w == '0) ? PH_HEADER : PH_INDEX;
                PH_INDEX:  phase_next = PH_NORMAL;
                PH_NORMAL: phase_next = PH_S;
                PH_S:      phase_next = PH_T;
                PH_T:      phase_next = last_vertex ? PH_HEADER : PH_INDEX;
                default:   phase_next = PH_HEADER;
            endcase
        end
    end

    // Datapath and result selection per phase
    always_comb
    begin
        vleft_next = vleft_reg;
        fan_next   = fan_reg;
        pos_next   = pos_reg;
        cur_next   = cur_reg;
        first_next = first_reg;
        prev_next  = prev_reg;
        total_next = total_reg;
        emit       = 1'b0;
        emit_kind  = KIND_TRIANGLE;
        tri_a      = first_reg;
        tri_b      = prev_reg;
        tri_c      = cur_full;
        if (accept)
        begin
            case (phase_reg)
                PH_HEADER:
                begin
                    if (w == '0)
                    begin
                        // close the mesh and report its corner total
                        emit       = 1'b1;
                        emit_kind  = KIND_MESH_END;
                        total_next = '0;
                    end
                    else
                    begin
                        fan_next   = w[WORD_W-1];
                        vleft_next = w[WORD_W-1] ? (~w + WORD_W'(1)) : w;
                        pos_next   = '0;
                    end
                end
                PH_INDEX:  cur_next.index = w[INDEX_W-1:0];
                PH_NORMAL: cur_next = cur_reg;
                PH_S:      cur_next.s = w;
                PH_T:
                begin
                    cur_next   = cur_full;
                    pos_next   = pos_reg + WORD_W'(1);
                    vleft_next = last_vertex ? '0 : vleft_reg - WORD_W'(1);
                    if (pos_reg == '0)
                    begin
                        first_next = cur_full;
                    end
                    else if (pos_reg == WORD_W'(1))
                    begin
                        prev_next = cur_full;
                    end
                    else
                    begin
                        emit = 1'b1;
                        // odd strip positions swap winding
                        if (!fan_reg && pos_reg[0])
                        begin
                            tri_b = cur_full;
                            tri_c = prev_reg;
                        end
                        if (!fan_reg)
                        begin
                            first_next = prev_reg;
                        end
                        prev_next  = cur_full;
                        total_next = (total_reg > TOTAL_MAX - TOTAL_W'(3)) ?
                                     TOTAL_MAX : total_reg + TOTAL_W'(3);
                    end
                end
                default: cur_next = cur_reg;
            endcase
        end
    end

    // Output register: load a new result or drain the held one
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_kind_next  = out_kind_reg;
        out_data_next  = out_data_reg;
        if (accept && emit)
        begin
            out_valid_next = 1'b1;
            out_kind_next  = emit_kind;
            if (emit_kind == KIND_MESH_END)
            begin
                out_data_next = {{PAD_W{1'b0}}, total_reg, {TOTAL_LSB{1'b0}}};
            end
            else
            begin
                out_data_next = {{PAD_W{1'b0}}, {TOTAL_W{1'b0}}, tri_c, tri_b, tri_a};
            end
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HEADER;
            vleft_reg     <= '0;
            fan_reg       <= 1'b0;
            pos_reg       <= '0;
            cur_reg       <= '0;
            first_reg     <= '0;
            prev_reg      <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            vleft_reg     <= vleft_next;
            fan_reg       <= fan_next;
            pos_reg       <= pos_next;
            cur_reg       <= cur_next;
            first_reg     <= first_next;
            prev_reg      <= prev_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        out_kind_reg <= out_kind_next;
        out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = out_data_reg;
    assign m_axis_tuser[0] = out_kind_reg;

endmodule

FILE: rtl/sftl_checker.sv
// Port-level checker for the strip and fan converter, bound to the top level.
`timescale 1ns / 1ps
`include "strip_fan_to_triangle_list_unit_assert.svh"
module sftl_checker (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_axis_tvalid,
    input  logic                                 s_axis_tready,
    input  logic [sftl_pkg::WORD_W-1:0]          s_axis_tdata,
    input  logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    input  logic [sftl_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    input  logic [0:0]                           m_axis_tuser
);
    import sftl_pkg::*;

    logic mesh_end_seen;
    logic triangle_seen;
    logic stalled;
    logic out_free;
    logic no_accept;

    assign mesh_end_seen = m_axis_tvalid && (m_axis_tuser[0] == KIND_MESH_END);
    assign triangle_seen = m_axis_tvalid && (m_axis_tuser[0] == KIND_TRIANGLE);
    assign stalled       = m_axis_tvalid && !m_axis_tready;
    assign out_free      = !m_axis_tvalid || m_axis_tready;
    assign no_accept     = !(s_axis_tvalid && s_axis_tready);

    // a stalled result holds
    `SFTL_ASSERT_NXT(a_hold, clk, rst_n, stalled, m_axis_tvalid && $stable({m_axis_tuser, m_axis_tdata}))
    // a mesh end carries no corners
    `SFTL_ASSERT_IMP(a_end_no_corners, clk, rst_n, mesh_end_seen, m_axis_tdata[TOTAL_LSB-1:0] == '0)
    // a triangle carries no total and the pad stays clear
    `SFTL_ASSERT_IMP(a_tri_no_total, clk, rst_n, triangle_seen, m_axis_tdata[OUT_DATA_W-1:TOTAL_LSB] == '0)
    // no new result appears without an accepted word
    `SFTL_ASSERT_NXT(a_cause, clk, rst_n, no_accept && out_free, !m_axis_tvalid)

endmodule

bind strip_fan_to_triangle_list_unit sftl_checker u_sftl_checker (.*);
